// ===== sv/lgs_pkg.sv =====
// Life generation stencil: shared types, constants and helper functions.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

   localparam int MAX_ROWS_DEFAULT = 32;
   localparam int MAX_COLS_DEFAULT = 32;

   localparam int CFG_W = 6;
   localparam logic [CFG_W-1:0] GRID_ROWS_RESET = 6'd25;
   localparam logic [CFG_W-1:0] GRID_COLS_RESET = 6'd25;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int POS_W      = 5;

   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic {
      REG_GRID_ROWS = 1'b0,
      REG_GRID_COLS = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_SKIP = 2'd0,
      CMD_EMIT = 2'd1,
      CMD_LAST = 2'd2
   } cmd_kind_type;

   typedef enum logic {
      BK_RUN   = 1'b0,
      BK_FLUSH = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] rows_last;
      logic [CFG_W-1:0] cols_last;
      logic             restart;
   } grid_cfg_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic             alive;
      logic [1:0]       slot;
      logic [CFG_W-1:0] col;
   } cmd_type;

   function automatic logic life_rule(input logic [3:0] n, input logic self);
      return (n == 4'(BIRTH_COUNT)) || ((n == 4'(SURVIVE_COUNT)) && self);
   endfunction

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

endpackage

`default_nettype wire

// ===== sv/lgs_csr.sv =====
// Life generation stencil: grid_rows / grid_cols register file on an APB-style port.
// Clamps cfg's last indices to the grid caps, flags every write. Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_csr
   import lgs_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output grid_cfg_type               cfg
);

   localparam int CfgMax = (2 ** CFG_W) - 1;
   localparam int RowCap = (MAX_ROWS > CfgMax) ? CfgMax : MAX_ROWS;
   localparam int ColCap = (MAX_COLS > CfgMax) ? CfgMax : MAX_COLS;

   logic [CFG_W-1:0] grid_rows_ff, grid_rows_in;
   logic [CFG_W-1:0] grid_cols_ff, grid_cols_in;
   logic             wr_strobe;
   reg_index_type    wr_index;

   function automatic logic [CFG_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] cap);
      logic [CFG_W-1:0] r;
      if (v == '0) r = '0;
      else if (v > cap) r = cap - 1'b1;
      else r = v - 1'b1;
      return r;
   endfunction

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_index   = reg_index_type'(csr_paddr[2]);

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (wr_strobe) begin
         unique case (wr_index)
            REG_GRID_ROWS: grid_rows_in = csr_pwdata[CFG_W-1:0];
            REG_GRID_COLS: grid_cols_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= GRID_ROWS_RESET;
         grid_cols_ff <= GRID_COLS_RESET;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
      end
   end

   always_comb begin
      unique case (wr_index)
         REG_GRID_ROWS: csr_prdata = CSR_DATA_W'(grid_rows_ff);
         REG_GRID_COLS: csr_prdata = CSR_DATA_W'(grid_cols_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.rows_last = last_index(grid_rows_ff, CFG_W'(RowCap));
   assign cfg.cols_last = last_index(grid_cols_ff, CFG_W'(ColCap));
   assign cfg.restart   = wr_strobe;

endmodule

`default_nettype wire

// ===== sv/lgs_front.sv =====
// Life generation stencil front end: accepts input cells, tracks the raster position
// and classifies each item into a command for the back end. Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_front
   import lgs_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire grid_cfg_type          cfg,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [0] cell_alive
   input  wire logic                  queue_full,
   output logic                       push_valid,
   output cmd_type                    push_cmd
);

   localparam int CfgMax = (2 ** CFG_W) - 1;
   localparam int RowCap = (MAX_ROWS > CfgMax) ? CfgMax : MAX_ROWS;
   localparam int RowW   = (RowCap > 1) ? $clog2(RowCap) : 1;
   localparam int ColW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [RowW-1:0] in_row_ff, in_row_in;
   logic [ColW-1:0] in_col_ff, in_col_in;
   logic [1:0]      in_slot_ff, in_slot_in;
   logic            accept;
   logic            at_last;
   logic            at_row_end;
   logic            primed;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      at_row_end = (CFG_W'(in_col_ff) == cfg.cols_last);
      at_last    = at_row_end && (CFG_W'(in_row_ff) == cfg.rows_last);
      primed     = (in_row_ff > RowW'(1)) ||
                   ((in_row_ff == RowW'(1)) && (in_col_ff != '0));

      push_valid     = accept;
      push_cmd.alive = req_tdata[0];
      push_cmd.slot  = in_slot_ff;
      push_cmd.col   = CFG_W'(in_col_ff);
      if (at_last) push_cmd.kind = CMD_LAST;
      else if (primed) push_cmd.kind = CMD_EMIT;
      else push_cmd.kind = CMD_SKIP;

      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_slot_in = in_slot_ff;
      if (cfg.restart || (accept && at_last)) begin
         in_row_in  = '0;
         in_col_in  = '0;
         in_slot_in = '0;
      end else if (accept) begin
         if (at_row_end) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + 1'b1;
            in_slot_in = slot_next(in_slot_ff);
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         in_slot_ff <= '0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         in_slot_ff <= in_slot_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lgs_queue.sv =====
// Life generation stencil command queue: a short FIFO between front and back end.
// Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_queue
   import lgs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_cmd,
   output logic         queue_full,
   input  wire logic    pop,
   output logic         queue_empty,
   output cmd_type      head_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      queue_full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      queue_empty = (count_ff == '0);
      do_push     = push_valid && !queue_full;
      do_pop      = pop && !queue_empty;
      head_cmd    = entry_ff[rd_ptr_ff];

      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

// ===== sv/lgs_back.sv =====
// Life generation stencil back end: row window, emit position, 3x3 rule and the
// registered result stage. Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_back
   import lgs_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire grid_cfg_type          cfg,
   input  wire logic                  queue_empty,
   input  wire cmd_type               head_cmd,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // [0] next_alive, [5:1] out_row,
                                                   // [10:6] out_col, [15:11] zero
   output logic                       rsp_tlast,   // run_last
   output logic                       rsp_tuser    // frame_end
);

   localparam int CfgMax = (2 ** CFG_W) - 1;
   localparam int RowCap = (MAX_ROWS > CfgMax) ? CfgMax : MAX_ROWS;
   localparam int RowW   = (RowCap > 1) ? $clog2(RowCap) : 1;
   localparam int ColW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   back_state_type  state_ff, state_in;
   logic [RowW-1:0] er_ff, er_in;
   logic [ColW-1:0] ec_ff, ec_in;
   logic [1:0]      er_slot_ff, er_slot_in;

   logic [MAX_COLS-1:0] win_ff [3];

   logic             out_valid_ff, out_valid_in;
   logic             out_alive_ff;
   logic [POS_W-1:0] out_row_ff;
   logic [POS_W-1:0] out_col_ff;
   logic             out_last_ff;
   logic             out_end_ff;

   logic                can_load;
   logic                load;
   logic                win_we;
   logic [MAX_COLS-1:0] up_row, mid_row, dn_row;
   logic                up_ok, dn_ok, lf_ok, rt_ok;
   logic [ColW-1:0]     ec_m1, ec_p1;
   logic                steady_emit;
   logic                dn_rt;
   logic [3:0]          n_live;
   logic                self_alive;
   logic                next_alive;
   logic                at_row_end;
   logic                at_end;

   assign can_load = !out_valid_ff || rsp_tready;

   always_comb begin
      case (er_slot_ff)
         2'd0: begin
            up_row = win_ff[2]; mid_row = win_ff[0]; dn_row = win_ff[1];
         end
         2'd1: begin
            up_row = win_ff[0]; mid_row = win_ff[1]; dn_row = win_ff[2];
         end
         default: begin
            up_row = win_ff[1]; mid_row = win_ff[2]; dn_row = win_ff[0];
         end
      endcase

      up_ok      = (er_ff != '0);
      dn_ok      = (CFG_W'(er_ff) != cfg.rows_last);
      lf_ok      = (ec_ff != '0);
      at_row_end = (CFG_W'(ec_ff) == cfg.cols_last);
      rt_ok      = !at_row_end;
      at_end     = at_row_end && !dn_ok;
      ec_m1      = ec_ff - 1'b1;
      ec_p1      = ec_ff + 1'b1;

      steady_emit = (state_ff == BK_RUN);
      dn_rt       = steady_emit ? head_cmd.alive : (rt_ok && dn_row[ec_p1]);

      n_live = 4'(up_ok && lf_ok && up_row[ec_m1])
             + 4'(up_ok && up_row[ec_ff])
             + 4'(up_ok && rt_ok && up_row[ec_p1])
             + 4'(lf_ok && mid_row[ec_m1])
             + 4'(rt_ok && mid_row[ec_p1])
             + 4'(dn_ok && lf_ok && dn_row[ec_m1])
             + 4'(dn_ok && dn_row[ec_ff])
             + 4'(dn_ok && rt_ok && dn_rt);
      self_alive = mid_row[ec_ff];
      next_alive = life_rule(n_live, self_alive);
   end

   always_comb begin
      state_in   = state_ff;
      er_in      = er_ff;
      ec_in      = ec_ff;
      er_slot_in = er_slot_ff;
      pop        = 1'b0;
      win_we     = 1'b0;
      load       = 1'b0;

      unique case (state_ff)
         BK_RUN: begin
            if (!queue_empty) begin
               unique case (head_cmd.kind)
                  CMD_SKIP: begin
                     win_we = 1'b1;
                     pop    = 1'b1;
                  end
                  CMD_EMIT: begin
                     if (can_load) begin
                        win_we = 1'b1;
                        pop    = 1'b1;
                        load   = 1'b1;
                     end
                  end
                  CMD_LAST: begin
                     win_we   = 1'b1;
                     pop      = 1'b1;
                     state_in = BK_FLUSH;
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         BK_FLUSH: begin
            if (can_load) begin
               load = 1'b1;
               if (at_end) state_in = BK_RUN;
            end
         end
         default: state_in = BK_RUN;
      endcase

      if (load) begin
         if (at_end) begin
            er_in      = '0;
            ec_in      = '0;
            er_slot_in = '0;
         end else if (at_row_end) begin
            ec_in      = '0;
            er_in      = er_ff + 1'b1;
            er_slot_in = slot_next(er_slot_ff);
         end else begin
            ec_in = ec_ff + 1'b1;
         end
      end

      if (cfg.restart) begin
         state_in   = BK_RUN;
         er_in      = '0;
         ec_in      = '0;
         er_slot_in = '0;
      end

      if (load) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         er_ff        <= '0;
         ec_ff        <= '0;
         er_slot_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         er_ff        <= er_in;
         ec_ff        <= ec_in;
         er_slot_ff   <= er_slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_we) win_ff[head_cmd.slot][head_cmd.col[ColW-1:0]] <= head_cmd.alive;
      if (load) begin
         out_alive_ff <= next_alive;
         out_row_ff   <= POS_W'(er_ff);
         out_col_ff   <= POS_W'(ec_ff);
         out_last_ff  <= steady_emit || at_end;
         out_end_ff   <= at_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_col_ff, out_row_ff, out_alive_ff});
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_end_ff;

endmodule

`default_nettype wire

// ===== sv/life_generation_stencil.sv =====
// Life generation stencil top level: one Conway Life (B3/S23) generation over a streamed grid.
// Instantiates lgs_csr, lgs_front, lgs_queue and lgs_back; depends on lgs_pkg.
//
// Cells of the current generation enter one per cycle while the command queue has room, in
// raster order over a grid of grid_rows x grid_cols cells; cells outside the grid count as
// dead. The next state of raster cell j leaves as the input cell j+grid_cols+1 is taken,
// one result per item, with tlast set. The last cell of a frame flushes the remaining
// grid_cols+2 cells (fewer on small grids); the back end works through them one by one while
// the four-entry command queue keeps taking input. Results sit in an output register, so a
// stalled result does not stop the input side until the queue fills. tuser marks the
// grid's final cell. A register write restarts the frame at the first cell; write only
// while the block is idle. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_stencil
   import lgs_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [0] cell_alive, [7:1] zero
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // [0] next_alive, [5:1] out_row,
                                                   // [10:6] out_col, [15:11] zero
   output logic                       rsp_tlast,   // run_last
   output logic                       rsp_tuser,   // frame_end
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   grid_cfg_type cfg;
   logic         queue_full;
   logic         queue_empty;
   logic         push_valid;
   cmd_type      push_cmd;
   cmd_type      head_cmd;
   logic         pop;

   lgs_csr #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lgs_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   lgs_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd),
      .queue_full  (queue_full),
      .pop         (pop),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd)
   );

   lgs_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== dv/tb_life_generation_stencil.sv =====
// Testbench for life_generation_stencil: streams Life generations over grids of many shapes,
// predicts every next-generation cell in-bench and checks each result item in order.
// Depends on lgs_pkg and the life_generation_stencil RTL.
`timescale 1ns / 1ps

module tb_life_generation_stencil;
   import lgs_pkg::*;

   localparam int IDLE_WAIT = 2 * (MAX_COLS_DEFAULT + 3) + 30;

   typedef struct packed {
      logic       next_alive;
      logic [4:0] row;
      logic [4:0] col;
      logic       run_last;
      logic       frame_end;
   } next_cell_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [0] cell_alive, [7:1] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [0] next_alive, [5:1] out_row, [10:6] out_col
   logic                  rsp_tlast;   // run_last
   logic                  rsp_tuser;   // frame_end
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   next_cell_type next_gen_q[$];
   logic [31:0]   window_rows[3];
   int            in_row, in_col, emit_row, emit_col;
   logic [5:0]    grid_rows_reg, grid_cols_reg;
   int unsigned   send_idle_pct, rsp_stall_pct;
   int            mismatch_count, cells_sent, results_seen, frames_done, csr_writes;

   life_generation_stencil uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic int eff_size(input logic [5:0] v, input int limit);
      if (v == 6'd0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic int neighbor_bit(input int r, input int c, input int rows, input int cols,
                                       input logic now_bit);
      if (r < 0 || c < 0 || r >= rows || c >= cols) return 0;
      if (r == in_row && c == in_col) return int'(now_bit);
      return int'(window_rows[r % 3][c]);
   endfunction

   function automatic logic life_next(input int r, input int c, input int rows, input int cols,
                                      input logic now_bit);
      int n;
      int own;
      n = 0;
      for (int dr = -1; dr <= 1; dr++)
         for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) n += neighbor_bit(r + dr, c + dc, rows, cols, now_bit);
      own = neighbor_bit(r, c, rows, cols, now_bit);
      return (n == BIRTH_COUNT) || (n == SURVIVE_COUNT && own == 1);
   endfunction

   task automatic step_life(input logic alive);
      int            rows, cols, total, idx, e;
      logic          is_last, have_prev;
      next_cell_type res, prev;
      rows = eff_size(grid_rows_reg, MAX_ROWS_DEFAULT);
      cols = eff_size(grid_cols_reg, MAX_COLS_DEFAULT);
      total = rows * cols;
      idx = in_row * cols + in_col;
      is_last = (idx + 1 >= total);
      have_prev = 1'b0;
      prev = '0;
      while (1'b1) begin
         e = emit_row * cols + emit_col;
         if (e >= total) break;
         if (!is_last && e + cols + 1 > idx) break;
         res.next_alive = life_next(emit_row, emit_col, rows, cols, alive);
         res.row = 5'(emit_row);
         res.col = 5'(emit_col);
         res.run_last = 1'b0;
         res.frame_end = (e + 1 == total);
         if (have_prev) next_gen_q.push_back(prev);
         prev = res;
         have_prev = 1'b1;
         emit_col++;
         if (emit_col >= cols) begin
            emit_col = 0;
            emit_row++;
         end
      end
      if (have_prev) begin
         prev.run_last = 1'b1;
         next_gen_q.push_back(prev);
      end
      window_rows[in_row % 3][in_col] = alive;
      if (is_last) begin
         in_row = 0;
         in_col = 0;
         emit_row = 0;
         emit_col = 0;
         frames_done++;
      end else begin
         in_col++;
         if (in_col >= cols) begin
            in_col = 0;
            in_row++;
         end
      end
   endtask

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] error: %s", $time, msg);
   endtask

   always @(posedge clock) begin : check_results
      next_cell_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got.next_alive = rsp_tdata[0];
         got.row = rsp_tdata[5:1];
         got.col = rsp_tdata[10:6];
         got.run_last = rsp_tlast;
         got.frame_end = rsp_tuser;
         if (next_gen_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result cell (%0d,%0d) alive=%0d last=%0d end=%0d",
                                    got.row, got.col, got.next_alive, got.run_last,
                                    got.frame_end));
         end else begin
            want = next_gen_q.pop_front();
            if (got != want)
               flag_mismatch($sformatf({"expected cell (%0d,%0d) alive=%0d last=%0d end=%0d, ",
                                        "got cell (%0d,%0d) alive=%0d last=%0d end=%0d"},
                                       want.row, want.col, want.next_alive, want.run_last,
                                       want.frame_end, got.row, got.col, got.next_alive,
                                       got.run_last, got.frame_end));
         end
      end
   end

   task automatic send_cell(input logic alive);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= REQ_DATA_W'(alive);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      cells_sent++;
      step_life(alive);
   endtask

   task automatic hold_req();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input int count, input int density);
      for (int i = 0; i < count; i++) send_cell($urandom_range(99) < density);
   endtask

   task automatic wait_idle();
      while (next_gen_q.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [5:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == REG_GRID_ROWS) grid_rows_reg = value;
      else grid_cols_reg = value;
      in_row = 0;
      in_col = 0;
      emit_row = 0;
      emit_col = 0;
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic csr_check(input reg_index_type idx, input logic [5:0] want);
      logic [CSR_DATA_W-1:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(4 * int'(idx));
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got != CSR_DATA_W'(want))
         flag_mismatch($sformatf("register %s read 0x%0h, expected 0x%0h", idx.name(), got, want));
   endtask

   // which: 0 writes both registers, 1 rows only, 2 cols only
   task automatic set_grid(input logic [5:0] rows_v, input logic [5:0] cols_v, input int which);
      wait_idle();
      if (which != 2) begin
         csr_write(REG_GRID_ROWS, rows_v);
         csr_check(REG_GRID_ROWS, rows_v);
      end
      if (which != 1) begin
         csr_write(REG_GRID_COLS, cols_v);
         csr_check(REG_GRID_COLS, cols_v);
      end
   endtask

   task automatic test_reset_values();
      csr_check(REG_GRID_ROWS, GRID_ROWS_RESET);
      csr_check(REG_GRID_COLS, GRID_COLS_RESET);
      send_frame(40, 50);
      hold_req();
   endtask

   task automatic test_tiny_grid();
      set_grid(6'd0, 6'd0, 0);
      send_cell(1'b0);
      send_cell(1'b1);
      hold_req();
   endtask

   task automatic test_small_patterns();
      logic [8:0] blinker;
      blinker = 9'b000_111_000;
      set_grid(6'd3, 6'd3, 0);
      for (int i = 0; i < 9; i++) send_cell(1'b1);
      for (int i = 0; i < 9; i++) send_cell(blinker[i]);
      hold_req();
   endtask

   task automatic test_largest_grids();
      set_grid(6'd2, 6'd32, 0);
      send_frame(64, $urandom_range(20, 80));
      hold_req();
      set_grid(6'($urandom_range(33, 63)), 6'd1, 0);
      send_frame(32, $urandom_range(20, 80));
      hold_req();
      set_grid(6'd1, 6'd63, 0);
      send_frame(32, $urandom_range(20, 80));
      hold_req();
   endtask

   task automatic test_random_grids(input int quota);
      int start, kind, rv, cv, which, rows, cols, total, frames, n;
      start = cells_sent;
      while (cells_sent - start < quota) begin
         kind = $urandom_range(9);
         rv = $urandom_range(1, 6);
         cv = $urandom_range(1, 6);
         if (kind == 0) begin
            if ($urandom_range(1)) rv = 0;
            else cv = 0;
         end else if (kind == 1) begin
            if ($urandom_range(1)) begin
               rv = $urandom_range(33, 63);
               cv = $urandom_range(1, 2);
            end else begin
               cv = $urandom_range(33, 63);
               rv = $urandom_range(1, 2);
            end
         end
         which = (kind < 3) ? 0 : $urandom_range(2);
         if (which == 1 && eff_size(grid_cols_reg, MAX_COLS_DEFAULT) > 6) which = 0;
         if (which == 2 && eff_size(grid_rows_reg, MAX_ROWS_DEFAULT) > 6) which = 0;
         set_grid(6'(rv), 6'(cv), which);
         rows = eff_size(grid_rows_reg, MAX_ROWS_DEFAULT);
         cols = eff_size(grid_cols_reg, MAX_COLS_DEFAULT);
         total = rows * cols;
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            n = total;
            if (f == frames - 1 && total > 1 && $urandom_range(4) == 0)
               n = $urandom_range(1, total - 1);
            send_frame(n, $urandom_range(100));
         end
         hold_req();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      for (int i = 0; i < 3; i++) window_rows[i] = '0;
      in_row = 0;
      in_col = 0;
      emit_row = 0;
      emit_col = 0;
      grid_rows_reg = GRID_ROWS_RESET;
      grid_cols_reg = GRID_COLS_RESET;
      mismatch_count = 0;
      cells_sent = 0;
      results_seen = 0;
      frames_done = 0;
      csr_writes = 0;
      send_idle_pct = 7;
      rsp_stall_pct = 7;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_tiny_grid();
      test_small_patterns();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 59;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 59;
            end
            default: begin
               send_idle_pct = 7;
               rsp_stall_pct = 7;
            end
         endcase
         test_random_grids(20);
         if (p == 2) test_largest_grids();
      end

      wait_idle();
      $display("Streamed %0d cells (%0d complete frames) and checked %0d results,",
               cells_sent, frames_done, results_seen);
      $display("across %0d register writes and four idle/stall mixes", csr_writes);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
